// File: hdl/cmf_pkg.sv
// Shared types and constants for the cross morphology filter.
// No dependencies; imported by every module of the block.
package cmf_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int GEO_W     = 11;
  localparam int WCMP_W    = (COL_W + 1 > GEO_W) ? COL_W + 1 : GEO_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

  localparam logic [1:0] MODE_ERODE   = 2'd0;
  localparam logic [1:0] MODE_DILATE  = 2'd1;
  localparam logic [1:0] MODE_REPLACE = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       fg;
    logic [7:0]       bg;
    logic [GEO_W-1:0] width;
    logic [GEO_W-1:0] height;
  } cfg_t;

  // One line store word: two rows back and one row back at a column
  typedef struct packed {
    logic [7:0] up;
    logic [7:0] mid;
  } lsw_t;

  // Window handed from front to back
  typedef struct packed {
    logic [7:0] ctr;
    logic [7:0] up;
    logic [7:0] lft;
    logic [7:0] rgt;
    logic [7:0] dwn;
    logic       up_v;
    logic       lft_v;
    logic       rgt_v;
    logic       dwn_v;
    logic       last;
  } win_t;

endpackage

// File: hdl/cmf_front.sv
// Front end: accepts words, tracks raster position, owns the line store and
// assembles the cross window. Depends on cmf_pkg.
module cmf_front import cmf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       geo_clr,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       q_full,
  output logic       push,
  output win_t       win
);

  // Combined line store: {row r-2, row r-1} per column
  lsw_t mem [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [GEO_W-1:0] row_r, row_nxt;
  lsw_t             rd_r;        // always mem[col_r + 1]
  lsw_t             cur_r;       // mem[col_r] for col_r >= 2
  lsw_t             shd0_r;      // live copies of columns 0 and 1
  lsw_t             shd1_r;
  logic [7:0]       left_r;

  logic [WCMP_W-1:0] w_ext, w_eff;
  logic [COL_W-1:0]  wm1;
  logic [GEO_W-1:0]  h_eff;
  logic              accept, frame_in, pix_take, drn_take, row_end;
  lsw_t              cur_val, wr_word;
  logic [COL_W-1:0]  rd_addr;

  assign w_ext = WCMP_W'(cfg.width);
  always_comb begin
    w_eff = w_ext;
    if (w_ext == '0) w_eff = WCMP_W'(1);
    if (w_ext > WCMP_W'(MAX_WIDTH)) w_eff = WCMP_W'(MAX_WIDTH);
  end
  assign wm1   = COL_W'(w_eff - WCMP_W'(1));
  assign h_eff = (cfg.height == '0) ? GEO_W'(1) : cfg.height;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign frame_in  = row_r >= h_eff;
  assign pix_take  = accept && (in_tuser == OP_PIXEL) && !frame_in;
  assign drn_take  = accept && (in_tuser == OP_DRAIN) && frame_in;
  assign row_end   = col_r == wm1;

  // columns 0 and 1 come from the shadows: the registered read has no
  // time to catch up at a row wrap
  always_comb begin
    if (col_r == '0)                cur_val = shd0_r;
    else if (col_r == COL_W'(1))    cur_val = shd1_r;
    else                            cur_val = cur_r;
  end

  assign wr_word = '{up: cur_val.mid, mid: in_tdata};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geo_clr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (pix_take) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + GEO_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end else if (drn_take) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  assign rd_addr = col_nxt + COL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) mem[col_r] <= wr_word;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pix_take || drn_take) begin
      cur_r  <= rd_r;
      left_r <= cur_val.mid;
    end
    if (pix_take && col_r == '0)         shd0_r <= wr_word;
    if (pix_take && col_r == COL_W'(1))  shd1_r <= wr_word;
  end

  always_comb begin
    win.ctr   = cur_val.mid;
    win.up    = cur_val.up;
    win.lft   = left_r;
    win.rgt   = (col_r == '0) ? shd1_r.mid : rd_r.mid;
    win.dwn   = in_tdata;
    win.up_v  = pix_take ? (row_r > GEO_W'(1)) : (h_eff > GEO_W'(1));
    win.lft_v = col_r != '0;
    win.rgt_v = !row_end;
    win.dwn_v = pix_take;
    win.last  = drn_take && row_end;
  end

  // row 0 pixels only fill the store
  assign push = (pix_take && row_r != '0) || drn_take;

endmodule

// File: hdl/cmf_fifo.sv
// Two-entry window queue between front and back.
// Depends on cmf_pkg.
module cmf_fifo import cmf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  win_t push_data,
  input  logic pop,
  output logic full,
  output logic valid,
  output win_t pop_data
);

  win_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_data = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + Q_PTR_W'(1);
      if (pop)  rp_r <= rp_r + Q_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

endmodule

// File: hdl/cmf_back.sv
// Back end: applies erosion, dilation, replace or pass-through to a window and holds the
// result in the output register. Depends on cmf_pkg.
module cmf_back import cmf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  win_t       q_data,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic       ov_r;
  logic [7:0] od_r;
  logic       ol_r;
  logic       all_fg, any_fg, ctr_fg;
  logic [7:0] res;

  // missing neighbours count as foreground for all, as absent for any
  always_comb begin
    all_fg = (!q_data.up_v  || q_data.up  == cfg.fg) &&
             (!q_data.lft_v || q_data.lft == cfg.fg) &&
             (!q_data.rgt_v || q_data.rgt == cfg.fg) &&
             (!q_data.dwn_v || q_data.dwn == cfg.fg);
    any_fg = (q_data.up_v  && q_data.up  == cfg.fg) ||
             (q_data.lft_v && q_data.lft == cfg.fg) ||
             (q_data.rgt_v && q_data.rgt == cfg.fg) ||
             (q_data.dwn_v && q_data.dwn == cfg.fg);
    ctr_fg = q_data.ctr == cfg.fg;
    case (cfg.mode)
      MODE_ERODE:   res = (ctr_fg && !all_fg) ? cfg.bg : q_data.ctr;
      MODE_DILATE:  res = (!ctr_fg && any_fg) ? cfg.fg : q_data.ctr;
      MODE_REPLACE: res = ctr_fg ? cfg.bg : q_data.ctr;
      default:      res = q_data.ctr;
    endcase
  end

  assign q_pop = q_valid && (!ov_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (q_pop) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      od_r <= res;
      ol_r <= q_data.last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule

// File: hdl/cross_morphology_filter_unit.sv
// Top level of the cross morphology filter: configuration registers and the
// front / queue / back chain. Depends on cmf_pkg, cmf_front, cmf_fifo, cmf_back.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------
//  in_      | in  | in_tvalid/in_tready  | tdata: pixel_in[7:0]; tuser: opcode
//  out_     | out | out_tvalid/out_tready| tdata: pixel_out[7:0]; tlast: frame_last
//  cfg_     | in  | cfg_we               | cfg_index[2:0], cfg_wdata[10:0]
//
// One word per cycle in both directions while out_tready stays high; a window is
// registered into the queue by the front, then popped by the back into the out reg.
// The line store is a single-port-write, one-read 16-bit memory read one
// column ahead; columns 0 and 1 are mirrored in flops to cover the row wrap.
// Reset is synchronous, active low; no clearing pass, store contents are
// only read once written in the current frame.
// in_tready drops only when the two-entry queue is full.
module cross_morphology_filter_unit import cmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] pixel_in
  input  logic                  in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] pixel_out
  output logic                  out_tlast,  // frame_last
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic geo_clr;
  logic q_full, q_valid, q_push, q_pop;
  win_t q_in, q_out;

  // writing either geometry register restarts the frame
  assign geo_clr = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_ERODE;
      cfg_r.fg     <= 8'd88;
      cfg_r.bg     <= 8'd46;
      cfg_r.width  <= GEO_W'(1024);
      cfg_r.height <= GEO_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   cfg_r.mode   <= cfg_wdata[1:0];
        REG_FG:     cfg_r.fg     <= cfg_wdata[7:0];
        REG_BG:     cfg_r.bg     <= cfg_wdata[7:0];
        REG_WIDTH:  cfg_r.width  <= cfg_wdata[GEO_W-1:0];
        REG_HEIGHT: cfg_r.height <= cfg_wdata[GEO_W-1:0];
        default:    ; // unmapped index, dropped
      endcase
    end
  end

  cmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .geo_clr   (geo_clr),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .win       (q_in)
  );

  cmf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  cmf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/sv/tb_top.sv
// Testbench for cross_morphology_filter_unit: streams character frames
// through the 4-neighbour erode / dilate / replace filter against a predictor.
// Depends on cmf_pkg and the RTL under hdl/; needs nothing else.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cmf_pkg::*;

  // Mode 3 has no name in the package: it passes pixels through untouched.
  localparam logic [1:0] MODE_PASS = 2'd3;
  localparam int STALL_PCT = 26;
  localparam int BODY_WORDS = 1750;

  // ---------------------------------------------------------------------------
  // Scoreboard: owns a private copy of the filter state and config, predicts
  // the filtered pixel for every accepted word and holds the expected words.
  // ---------------------------------------------------------------------------
  class cross_filter_board;
    typedef struct packed {
      logic [7:0] px;
      logic       last;
    } pixel_word_t;

    logic [7:0]       row_up  [MAX_WIDTH];   // two rows back
    logic [7:0]       row_mid [MAX_WIDTH];   // one row back
    int unsigned      in_col, in_row, out_col, out_row;
    logic [1:0]       mode;
    logic [7:0]       fg, bg;
    logic [GEO_W-1:0] width_reg, height_reg;
    pixel_word_t      expected_pixels[$];
    int               errors;
    int               checked;

    function new();
      foreach (row_up[i]) begin
        row_up[i]  = '0;
        row_mid[i] = '0;
      end
      restart_frame();
      mode       = MODE_ERODE;
      fg         = 8'd88;
      bg         = 8'd46;
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      errors     = 0;
      checked    = 0;
    endfunction

    function void restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    // width 0 reads as 1, anything past the store depth as the depth
    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void add_expected(pixel_word_t ow);
      expected_pixels.insert(expected_pixels.size(), ow);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MODE: mode = val[1:0];
        REG_FG: fg = val[7:0];
        REG_BG: bg = val[7:0];
        REG_WIDTH: begin
          width_reg = val[GEO_W-1:0];
          restart_frame();
        end
        REG_HEIGHT: begin
          height_reg = val[GEO_W-1:0];
          restart_frame();
        end
        default: ;
      endcase
    endfunction

    // nb holds the n neighbours that lie inside the frame
    function logic [7:0] morph_pixel(logic [7:0] ctr, logic [7:0] nb [4], int n);
      bit all_fg;
      bit any_fg;
      int k;
      all_fg = 1'b1;
      any_fg = 1'b0;
      for (k = 0; k < n; k++) begin
        if (nb[k] == fg) any_fg = 1'b1;
        else all_fg = 1'b0;
      end
      case (mode)
        MODE_ERODE: return (ctr == fg && !all_fg) ? bg : ctr;
        MODE_DILATE: return (ctr != fg && any_fg) ? fg : ctr;
        MODE_REPLACE: return (ctr == fg) ? bg : ctr;
        default: return ctr;
      endcase
    endfunction

    function bit step_out(int unsigned w, int unsigned h);
      bit last;
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      return last;
    endfunction

    function void pixel_word_in(logic op, logic [7:0] px);
      int unsigned w, h, c;
      logic [7:0]  nb [4];
      int          n;
      pixel_word_t ow;
      w = eff_w();
      h = eff_h();
      n = 0;
      if (op == OP_PIXEL) begin
        if (in_row >= h) return;          // frame fully in, tail not drained
        c = (in_col >= w) ? w - 1 : in_col;
        if (in_row >= 1) begin
          // window centred one row up; the new pixel is its lower neighbour
          if (in_row >= 2) begin
            nb[n] = row_up[c];
            n++;
          end
          if (c > 0) begin
            nb[n] = row_up[c-1];
            n++;
          end
          if (c + 1 < w) begin
            nb[n] = row_mid[c+1];
            n++;
          end
          nb[n] = px;
          n++;
          ow.px   = morph_pixel(row_mid[c], nb, n);
          ow.last = 1'b0;
          void'(step_out(w, h));
          add_expected(ow);
        end
        row_up[c]  = row_mid[c];
        row_mid[c] = px;
        in_col     = c + 1;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end else begin
        if (in_row < h) return;           // drain before the frame is in
        c = (out_col >= w) ? w - 1 : out_col;
        if (out_row >= 1) begin
          nb[n] = row_up[c];
          n++;
        end
        if (c > 0) begin
          nb[n] = row_mid[c-1];
          n++;
        end
        if (c + 1 < w) begin
          nb[n] = row_mid[c+1];
          n++;
        end
        ow.px   = morph_pixel(row_mid[c], nb, n);
        ow.last = step_out(w, h);
        if (ow.last) restart_frame();
        add_expected(ow);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 20) $display("tb: mismatch: %s", msg);
    endtask

    task check_pixel_out(logic [7:0] px, logic last);
      pixel_word_t want;
      checked++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("word %0d: 0x%02h arrived with nothing expected",
                                  checked, px));
        return;
      end
      want = expected_pixels.pop_front();
      if (px !== want.px)
        report_mismatch($sformatf("word %0d: pixel 0x%02h, want 0x%02h",
                                  checked, px, want.px));
      if (last !== want.last)
        report_mismatch($sformatf("word %0d: tlast %0b, want %0b",
                                  checked, last, want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [7:0] pixel_in
  logic                  in_tuser   = 1'b0; // [0] opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // [7:0] pixel_out
  logic                  out_tlast;         // frame_last
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  cross_morphology_filter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  cross_filter_board sb;

  int in_idle_pct  = STALL_PCT;
  int out_idle_pct = STALL_PCT;
  int fg_bias      = 50;     // percent of frame pixels equal to fg
  int body_words   = 0;      // words of the random frames
  int frames_done  = 0;

  initial forever #6 clk = ~clk;

  // Hard stop in case the block hangs or drops words.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver back-pressure, redrawn every cycle on the falling edge.
  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= out_idle_pct);

  // Both handshakes sampled in one place so a result is always checked before
  // the word accepted on the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_pixel_out(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.pixel_word_in(in_tuser, in_tdata);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic op, input logic [7:0] px);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Quiet the input, wait for every predicted word, then give the pipe time to
  // swallow any trailing word that makes no result.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return MODE_ERODE;
    if (r < 8) return MODE_DILATE;
    if (r < 9) return MODE_REPLACE;
    return MODE_PASS;
  endfunction

  function automatic logic [7:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < fg_bias) return sb.fg;
    if (r < fg_bias + 20) return sb.bg;
    return 8'($urandom);
  endfunction

  // Change the filter itself mid-frame while the pipe is empty.
  task automatic retune();
    write_cfg(REG_MODE, {9'd0, pick_mode()});
    if ($urandom_range(0, 1)) write_cfg(REG_FG, CFG_DATA_W'($urandom_range(0, 255)));
    else write_cfg(REG_BG, CFG_DATA_W'($urandom_range(0, 255)));
  endtask

  // One frame of pixels followed by one row of drain words. abort_at stops
  // early (the caller then rewrites geometry), noise_pct sprinkles ignored
  // words: early drains among the pixels, stray pixels among the drains.
  task automatic run_frame(input int abort_at, input int retune_at,
                           input int noise_pct, input bit tally);
    int unsigned w, h, total;
    int          k;
    w     = sb.eff_w();
    h     = sb.eff_h();
    total = w * h;
    for (k = 0; k < total; k++) begin
      if (k == abort_at) return;
      if (k == retune_at) begin
        settle();
        retune();
      end
      if ($urandom_range(0, 99) < noise_pct) send_word(OP_DRAIN, 8'($urandom));
      send_word(OP_PIXEL, pick_pixel());
      if (tally) body_words++;
    end
    for (k = 0; k < w; k++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(OP_PIXEL, 8'($urandom));
      send_word(OP_DRAIN, 8'($urandom));
      if (tally) body_words++;
    end
    frames_done++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          iter;
    int unsigned total, gi;
    int          abort_at, retune_at, noise;
    bit          need_geo;
    logic [10:0] gw, gh;

    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // -- directed --------------------------------------------------------------
    // 1x1 frame via zero geometry: no neighbours, so erosion keeps the pixel.
    // An early drain and a pixel past the frame end are both dropped.
    write_cfg(REG_WIDTH, 11'd0);
    write_cfg(REG_HEIGHT, 11'd0);
    send_word(OP_DRAIN, 8'hff);
    send_word(OP_PIXEL, 8'd88);
    send_word(OP_PIXEL, 8'd0);
    send_word(OP_DRAIN, 8'h00);
    settle();
    // same frame under dilation: background stays
    write_cfg(REG_MODE, {9'd0, MODE_DILATE});
    send_word(OP_PIXEL, 8'd46);
    send_word(OP_DRAIN, 8'h5a);
    settle();
    // 3x3 erosion with fg at the top code; the single hole eats the centre
    // and its side neighbours, borders only look at in-frame neighbours
    write_cfg(REG_MODE, {9'd0, MODE_ERODE});
    write_cfg(REG_FG, 11'd255);
    write_cfg(REG_BG, 11'd0);
    write_cfg(REG_WIDTH, 11'd3);
    write_cfg(REG_HEIGHT, 11'd3);
    fg_bias = 100;
    repeat (7) send_word(OP_PIXEL, 8'd255);
    send_word(OP_PIXEL, 8'd0);
    send_word(OP_PIXEL, 8'd255);
    repeat (3) send_word(OP_DRAIN, 8'h00);
    settle();
    // replace on a 2x1 row, then pass-through mode on a 1x1 frame
    write_cfg(REG_MODE, {9'd0, MODE_REPLACE});
    write_cfg(REG_WIDTH, 11'd2);
    write_cfg(REG_HEIGHT, 11'd1);
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_PIXEL, 8'd7);
    repeat (2) send_word(OP_DRAIN, 8'h00);
    settle();
    write_cfg(REG_MODE, {9'd0, MODE_PASS});
    write_cfg(REG_WIDTH, 11'd1);
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_DRAIN, 8'h00);
    settle();
    // writes past the last register must change nothing
    for (gi = REG_HEIGHT + 1; gi < (1 << CFG_IDX_W); gi++)
      write_cfg(gi[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));

    // -- random frames -----------------------------------------------------------
    iter     = 0;
    need_geo = 1'b1;
    while (body_words < BODY_WORDS) begin
      // one calm stretch with both sides streaming flat out
      in_idle_pct  = (iter >= 10 && iter < 22) ? 0 : STALL_PCT;
      out_idle_pct = in_idle_pct;
      fg_bias      = $urandom_range(30, 80);
      settle();
      if (iter == 3) begin
        // widest frame: oversize width clamps to the store depth, so the
        // first row wraps there; cut short a few words into the second row
        write_cfg(REG_MODE, {9'd0, pick_mode()});
        write_cfg(REG_WIDTH, 11'd2047);
        write_cfg(REG_HEIGHT, 11'd2);
        run_frame(MAX_WIDTH + 8, -1, 0, 1'b1);
        need_geo = 1'b1;
      end else if (iter == 7) begin
        // tallest frame, one column, cut short by the next geometry write
        write_cfg(REG_WIDTH, 11'd1);
        write_cfg(REG_HEIGHT, 11'd2047);
        run_frame(40, -1, 0, 1'b1);
        need_geo = 1'b1;
      end else begin
        if (need_geo || $urandom_range(0, 99) < 70) begin
          case ($urandom_range(0, 19))
            0: gw = 11'd0;
            1, 2: gw = 11'($urandom_range(9, 40));
            default: gw = 11'($urandom_range(1, 8));
          endcase
          gh = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
          write_cfg(REG_MODE, {9'd0, pick_mode()});
          write_cfg(REG_FG, CFG_DATA_W'($urandom_range(0, 255)));
          write_cfg(REG_BG, CFG_DATA_W'($urandom_range(0, 255)));
          if ($urandom_range(0, 9) == 0)
            write_cfg(CFG_IDX_W'($urandom_range(REG_HEIGHT + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
          if ($urandom_range(0, 1)) begin
            write_cfg(REG_WIDTH, gw);
            write_cfg(REG_HEIGHT, gh);
          end else begin
            write_cfg(REG_HEIGHT, gh);
            write_cfg(REG_WIDTH, gw);
          end
        end
        total     = sb.eff_w() * sb.eff_h();
        abort_at  = ($urandom_range(0, 99) < 8) ? $urandom_range(0, total - 1) : -1;
        retune_at = ($urandom_range(0, 99) < 10 && total > 1) ?
                    $urandom_range(1, total - 1) : -1;
        noise     = ($urandom_range(0, 99) < 25) ? 8 : 0;
        run_frame(abort_at, retune_at, noise, 1'b1);
        need_geo  = (abort_at >= 0);
      end
      iter++;
    end

    settle();
    repeat (8) @(posedge clk);
    $display("tb: %0d frames streamed, %0d words checked, %0d mismatches",
             frames_done, sb.checked, sb.errors);
    $display("tb: covered all modes, 1x1 up to 1024-wide frames, aborts and ignored words");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/cmf_pkg.sv
hdl/cmf_front.sv
hdl/cmf_fifo.sv
hdl/cmf_back.sv
hdl/cross_morphology_filter_unit.sv
tb/sv/tb_top.sv
